// File: rtl/depth_pixels_to_world_points_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth to world point block
// Clocked on clk and held off while rst_n is low; both names come from the
// module that uses the macro.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXELS_TO_WORLD_POINTS_ASSERT_SVH
`define DEPTH_PIXELS_TO_WORLD_POINTS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpw assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DPW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpw assertion failed");

`endif

// File: rtl/dpw_pkg.sv
// ----------------------------------------------------------------------------
// dpw_pkg
// Shared types and constants of the depth to world point block.
// ----------------------------------------------------------------------------
package dpw_pkg;

  // Image bounds; a pixel at or beyond them is dropped.
  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  localparam logic [19:0] MAX_DEPTH_RESET = 20'd614400;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 184;

  // Item kinds carried on in_tuser.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

  typedef logic [3:0] coef_idx_t;

  // Coefficient slots.
  localparam coef_idx_t COEF_FX = 4'd0;
  localparam coef_idx_t COEF_FY = 4'd1;
  localparam coef_idx_t COEF_CX = 4'd2;
  localparam coef_idx_t COEF_CY = 4'd3;
  localparam coef_idx_t COEF_R0 = 4'd4;
  localparam coef_idx_t COEF_T0 = 4'd13;
  localparam coef_idx_t COEF_T1 = 4'd14;
  localparam coef_idx_t COEF_T2 = 4'd15;

  // Queue depth between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic        load;
    coef_idx_t   idx;
    logic [31:0] val;
    logic [11:0] col;
    logic [11:0] row;
    logic [19:0] depth;
  } dpw_item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic nonempty;
  } dpw_qstat_t;

  // Result item; cam_x sits in the lowest bits.
  typedef struct packed {
    logic [31:0] world_z;
    logic [31:0] world_y;
    logic [31:0] world_x;
    logic [19:0] cam_z;
    logic [31:0] cam_y;
    logic [31:0] cam_x;
  } dpw_res_t;

endpackage

// File: rtl/depth_pixels_to_world_points.sv
// ----------------------------------------------------------------------------
// depth_pixels_to_world_points
// Back-projects depth pixels through a pinhole model into camera and world.
// ----------------------------------------------------------------------------
// The block takes one input transfer per clock while the queue has room and
// gives one result per cycle at full rate while out_tready is high: the back
// pipeline is eight register stages deep and moves one item each cycle unless
// a finished point waits on the output. Pixels whose depth is not positive, is
// above max_depth, or that fall outside the image are dropped in the front and
// cost no pipeline slot; coefficient loads produce no result but ride the
// pipeline and write their coefficient as they pass the stage that uses it, so
// loads and pixels take effect strictly in stream order. A four-entry queue
// sits between front and back: when the output is stalled the pipeline holds,
// the queue fills, and in_tready drops only once it is full. The user must write
// max_depth on the cfg channel only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module depth_pixels_to_world_points (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tuser: action (0 pixel, 1 coefficient load)
  input  logic                               in_tuser,
  // in_tdata from bit 0: coef_index[3:0], coef_value[35:4], pixel_col[47:36],
  // pixel_row[59:48], depth_value[80:60], zero pad[87:81]
  input  logic [dpw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata from bit 0: cam_x[31:0], cam_y[63:32], cam_z[83:64],
  // world_x[115:84], world_y[147:116], world_z[179:148], zero pad[183:180]
  output logic [dpw_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration channel: max_depth.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [19:0]                        cfg_data
);
  import dpw_pkg::*;

  dpw_qstat_t qstat;
  dpw_item_t  push_item;
  dpw_item_t  head_item;
  dpw_res_t   out_res;
  logic       push;
  logic       pop;

  // Front: accept, classify, drop pixels that give no point.
  dpw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // Queue: decouple the front from a stalled back.
  dpw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // Back: coefficient bank and the arithmetic pipeline.
  dpw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // Pack the result; pad the top nibble with zeros.
  assign out_tdata = {(OUT_TDATA_W - $bits(dpw_res_t))'(0), out_res};

endmodule

// File: rtl/dpw_front.sv
// ----------------------------------------------------------------------------
// dpw_front
// Accepts input transfers, holds max_depth and drops pixels that give no point.
// ----------------------------------------------------------------------------
module dpw_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_tuser,
  input  logic [dpw_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [19:0]                         cfg_data,
  input  dpw_pkg::dpw_qstat_t                 qstat,
  output logic                                push,
  output dpw_pkg::dpw_item_t                  push_item
);
  import dpw_pkg::*;

  logic [19:0]        max_depth_r;
  logic signed [20:0] depth_s;
  logic               depth_ok;
  logic               bounds_ok;
  logic               keep;

  assign cfg_ready = 1'b1;
  assign in_tready = !qstat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_depth_r <= MAX_DEPTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_depth_r <= cfg_data;
    end
  end

  assign depth_s = $signed(in_tdata[80:60]);

  always_comb begin
    push_item.load  = (in_tuser == ACT_LOAD);
    push_item.idx   = in_tdata[3:0];
    push_item.val   = in_tdata[35:4];
    push_item.col   = in_tdata[47:36];
    push_item.row   = in_tdata[59:48];
    push_item.depth = depth_s[19:0];
  end

  // Depth must be positive and not above max_depth.
  assign depth_ok  = !depth_s[20] && (depth_s[19:0] != 20'd0) &&
                     (depth_s[19:0] <= max_depth_r);
  assign bounds_ok = (32'(push_item.col) < MAX_COLUMNS) &&
                     (32'(push_item.row) < MAX_ROWS);
  assign keep      = push_item.load || (depth_ok && bounds_ok);
  assign push      = in_tvalid && in_tready && keep;

endmodule

// File: rtl/dpw_queue.sv
// ----------------------------------------------------------------------------
// dpw_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dpw_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dpw_pkg::dpw_item_t  push_item,
  input  logic                pop,
  output dpw_pkg::dpw_item_t  head_item,
  output dpw_pkg::dpw_qstat_t qstat
);
  import dpw_pkg::*;

  dpw_item_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     cnt_r;
  logic [QAW:0]     cnt_nxt;

  assign head_item      = mem_r[rd_ptr_r];
  assign qstat.full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign qstat.nonempty = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/dpw_back.sv
// ----------------------------------------------------------------------------
// dpw_back
// Eight-stage back-projection and rigid transform pipeline with coefficient bank.
// ----------------------------------------------------------------------------
`include "depth_pixels_to_world_points_assert.svh"

module dpw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dpw_pkg::dpw_qstat_t qstat,
  input  dpw_pkg::dpw_item_t  head_item,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output dpw_pkg::dpw_res_t   out_res
);
  import dpw_pkg::*;

  localparam int NSTAGE = 8;

  typedef struct packed {
    logic        load;
    coef_idx_t   idx;
    logic [31:0] val;
    logic [19:0] depth;
  } dpw_ctl_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  logic [31:0]        coef_r [16];
  logic [NSTAGE:1]    vld_r;
  dpw_ctl_t           ctl_r [1:NSTAGE];
  dpw_ctl_t           head_ctl;
  logic               advance;
  logic               trans2_load;

  logic signed [32:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [64:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [44:0] rx_r, ry_r, rx_nxt, ry_nxt;
  logic signed [64:0] rxs_tmp, rys_tmp;
  logic signed [65:0] prx_r, pry_r, prx_nxt, pry_nxt;
  logic signed [65:0] prxs_tmp, prys_tmp;
  logic signed [49:0] cx_sh, cy_sh;
  logic [31:0]        camx5_r, camy5_r, camx5_nxt, camy5_nxt;
  logic [31:0]        camx6_r, camy6_r, camx7_r, camy7_r, camx8_r, camy8_r;
  logic signed [31:0] cam_vec [3];
  logic signed [63:0] m_r [3][3];
  logic signed [63:0] m_nxt [3][3];
  logic signed [63:0] mr_tmp [3][3];
  logic signed [34:0] q_r [3][3];
  logic signed [34:0] q_nxt [3][3];
  logic signed [36:0] w_sum [3];
  logic [31:0]        w_r [3];
  logic [31:0]        w_nxt [3];

  // Freeze the whole pipe only while a finished point waits on the output.
  assign out_tvalid = vld_r[NSTAGE] && !ctl_r[NSTAGE].load;
  assign advance    = !out_tvalid || out_tready;
  assign pop        = advance && qstat.nonempty;

  always_comb begin
    head_ctl.load  = head_item.load;
    head_ctl.idx   = head_item.idx;
    head_ctl.val   = head_item.val;
    head_ctl.depth = head_item.depth;
  end

  // Stage 1: offset from the principal point.
  assign dx_nxt = $signed({17'b0, head_item.col, 4'b0}) - $signed(coef_r[COEF_CX]);
  assign dy_nxt = $signed({17'b0, head_item.row, 4'b0}) - $signed(coef_r[COEF_CY]);

  // Stage 2: scale by inverse focal length.
  assign px_nxt = dx_r * $signed(coef_r[COEF_FX]);
  assign py_nxt = dy_r * $signed(coef_r[COEF_FY]);

  // Stage 3: round the ratio.
  assign rxs_tmp = px_r + 65'sd524288;
  assign rys_tmp = py_r + 65'sd524288;
  assign rx_nxt  = rxs_tmp[64:20];
  assign ry_nxt  = rys_tmp[64:20];

  // Stage 4: multiply by depth.
  assign prx_nxt = rx_r * $signed({1'b0, ctl_r[3].depth});
  assign pry_nxt = ry_r * $signed({1'b0, ctl_r[3].depth});

  // Stage 5: round and saturate the camera point.
  assign prxs_tmp  = prx_r + 66'sd32768;
  assign prys_tmp  = pry_r + 66'sd32768;
  assign cx_sh     = prxs_tmp[65:16];
  assign cy_sh     = prys_tmp[65:16];
  assign camx5_nxt = sat32(64'(cx_sh));
  assign camy5_nxt = sat32(64'(cy_sh));

  // Stage 6: nine rotation products, stage 7: round each, stage 8: sum.
  always_comb begin
    cam_vec[0] = $signed(camx5_r);
    cam_vec[1] = $signed(camy5_r);
    cam_vec[2] = $signed({12'b0, ctl_r[5].depth});
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_nxt[i][j]  = $signed(coef_r[4'(COEF_R0 + 3 * i + j)]) * cam_vec[j];
        mr_tmp[i][j] = m_r[i][j] + 64'sd268435456;
        q_nxt[i][j]  = mr_tmp[i][j][63:29];
      end
      w_sum[i] = 37'(q_r[i][0]) + 37'(q_r[i][1]) + 37'(q_r[i][2]) +
                 37'($signed(coef_r[4'(COEF_T0 + i)]));
      w_nxt[i] = sat32(64'(w_sum[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[NSTAGE-1:1], qstat.nonempty};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl_r[1] <= head_ctl;
      for (int k = 2; k <= NSTAGE; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      rx_r    <= rx_nxt;
      ry_r    <= ry_nxt;
      prx_r   <= prx_nxt;
      pry_r   <= pry_nxt;
      camx5_r <= camx5_nxt;
      camy5_r <= camy5_nxt;
      camx6_r <= camx5_r;
      camy6_r <= camy5_r;
      camx7_r <= camx6_r;
      camy7_r <= camy6_r;
      camx8_r <= camx7_r;
      camy8_r <= camy7_r;
      m_r     <= m_nxt;
      q_r     <= q_nxt;
      w_r     <= w_nxt;
    end
  end

  // Each load writes its coefficient as it passes the stage that reads it,
  // so every pixel sees exactly the loads that came before it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        coef_r[i] <= '0;
      end
    end else if (advance) begin
      if (pop && head_item.load &&
          (head_item.idx == COEF_CX || head_item.idx == COEF_CY)) begin
        coef_r[head_item.idx] <= head_item.val;
      end
      if (vld_r[1] && ctl_r[1].load &&
          (ctl_r[1].idx == COEF_FX || ctl_r[1].idx == COEF_FY)) begin
        coef_r[ctl_r[1].idx] <= ctl_r[1].val;
      end
      if (vld_r[5] && ctl_r[5].load &&
          ctl_r[5].idx >= COEF_R0 && ctl_r[5].idx < COEF_T0) begin
        coef_r[ctl_r[5].idx] <= ctl_r[5].val;
      end
      if (vld_r[7] && ctl_r[7].load && ctl_r[7].idx >= COEF_T0) begin
        coef_r[ctl_r[7].idx] <= ctl_r[7].val;
      end
    end
  end

  always_comb begin
    out_res.cam_x   = camx8_r;
    out_res.cam_y   = camy8_r;
    out_res.cam_z   = ctl_r[NSTAGE].depth;
    out_res.world_x = w_r[0];
    out_res.world_y = w_r[1];
    out_res.world_z = w_r[2];
  end

  assign trans2_load = advance && vld_r[7] && ctl_r[7].load && (ctl_r[7].idx == COEF_T2);

  `DPW_ASSERT_IMPL(a_out_depth_nonzero, out_tvalid, out_res.cam_z != 20'd0)
  `DPW_ASSERT_NEXT(a_stall_freezes_pipe, !advance, $stable(vld_r))
  `DPW_ASSERT_NEXT(a_trans_load_lands, trans2_load, coef_r[COEF_T2] == $past(ctl_r[7].val))

endmodule

// File: tb/tb_depth_pixels_to_world_points.sv
// ----------------------------------------------------------------------------
// tb_depth_pixels_to_world_points
// Streams depth pixels and coefficient loads into the block, predicts each
// camera and world point in an internal fixed-point projector, and compares
// every result transfer field by field in arrival order. Both stream sides
// idle at random; max_depth is rewritten between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module tb_depth_pixels_to_world_points;
  import dpw_pkg::*;

  // Cycles to let loads still in the pipeline drain before going quiet.
  localparam int PIPE_SLACK = 32;
  localparam int PHASE_ITEMS = 140;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic                   in_tuser = ACT_PIXEL;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [19:0]            cfg_data = '0;

  // Projector state: frame coefficients and the active depth limit.
  logic signed [31:0] frame_coef [16];
  logic [19:0]        depth_limit;
  dpw_res_t           pending_points [$];
  int                 mismatch_count = 0;
  // Set for a stretch of the run to keep both sides busy every cycle.
  bit                 no_idle = 1'b0;

  depth_pixels_to_world_points dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold the run to a fixed budget; a hang counts as a failure.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver back-pressure: drop tready in about one cycle out of seven.
  always @(posedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  // ---------------------------------------------------------------- predictor

  // Round half up: floor((v + 2^(k-1)) / 2^k); >>> on longint is a floor.
  function automatic longint round_shr(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Back-project one accepted pixel and move it into the world frame.
  function automatic dpw_res_t project_pixel(logic [11:0] col, logic [11:0] row,
                                             logic [19:0] depth);
    longint   d;
    longint   dx;
    longint   dy;
    longint   cam_v [3];
    longint   w;
    longint   world_v [3];
    dpw_res_t pt;
    d  = longint'(depth);
    dx = longint'(col) * 16 - longint'(frame_coef[COEF_CX]);
    dy = longint'(row) * 16 - longint'(frame_coef[COEF_CY]);
    cam_v[0] = clamp32(round_shr(round_shr(dx * longint'(frame_coef[COEF_FX]), 20) * d, 16));
    cam_v[1] = clamp32(round_shr(round_shr(dy * longint'(frame_coef[COEF_FY]), 20) * d, 16));
    cam_v[2] = d;
    for (int i = 0; i < 3; i++) begin
      w = longint'(frame_coef[4'(COEF_T0 + i)]);
      for (int j = 0; j < 3; j++) begin
        w += round_shr(longint'(frame_coef[4'(COEF_R0 + 3 * i + j)]) * cam_v[j], 29);
      end
      world_v[i] = clamp32(w);
    end
    pt.cam_x   = cam_v[0][31:0];
    pt.cam_y   = cam_v[1][31:0];
    pt.cam_z   = depth;
    pt.world_x = world_v[0][31:0];
    pt.world_y = world_v[1][31:0];
    pt.world_z = world_v[2][31:0];
    return pt;
  endfunction

  // ----------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every result transfer with the oldest predicted point.
  always @(posedge clk) begin
    dpw_res_t got;
    dpw_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = dpw_res_t'(out_tdata[179:0]);
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_points[0];
        pending_points.delete(0);
        check_field("cam_x", want.cam_x, got.cam_x);
        check_field("cam_y", want.cam_y, got.cam_y);
        check_field("cam_z", want.cam_z, got.cam_z);
        check_field("world_x", want.world_x, got.world_x);
        check_field("world_y", want.world_y, got.world_y);
        check_field("world_z", want.world_z, got.world_z);
      end
    end
  end

  // ----------------------------------------------------------------- stimulus

  // Send one item, then update the projector once the transfer has happened.
  // Leave tvalid high so back-to-back items see no bubble.
  task automatic send_item(logic action, coef_idx_t idx, logic [31:0] val,
                           logic [11:0] col, logic [11:0] row, logic [20:0] depth);
    if (!no_idle && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {7'b0, depth, row, col, val, idx};
    do @(posedge clk); while (!in_tready);
    if (action == ACT_LOAD) begin
      frame_coef[idx] = val;
    end else if (!depth[20] && depth != '0 && depth[19:0] <= depth_limit) begin
      // 12-bit columns and rows always fall inside the image.
      pending_points.insert(pending_points.size(), project_pixel(col, row, depth[19:0]));
    end
  endtask

  // Loads carry junk in the pixel fields; the block must ignore it.
  task automatic load_coef(coef_idx_t idx, logic [31:0] val);
    send_item(ACT_LOAD, idx, val, 12'($urandom()), 12'($urandom()), 21'($urandom()));
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [20:0] depth);
    send_item(ACT_PIXEL, 4'($urandom()), $urandom(), col, row, depth);
  endtask

  // Stop sending and wait until every predicted point has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic write_depth_limit(logic [19:0] limit);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    depth_limit = limit;
  endtask

  // Plausible camera values most of the time, raw 32-bit noise when wild.
  function automatic logic [31:0] pick_coef(coef_idx_t idx, bit wild);
    if (wild) return $urandom();
    if (idx <= COEF_FY) return $urandom_range(2_147_483, 21_474_836);
    if (idx <= COEF_CY) return $urandom_range(0, 65535);
    if (idx < COEF_T0) return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
  endfunction

  // A depth that the block must drop under the current limit, but for the noise case.
  function automatic logic [20:0] dropped_depth();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 21'(32'd0 - $urandom_range(1, 1 << 20));
      2: begin
        if (depth_limit == 20'hFFFFF) return 21'h100000;
        return 21'($urandom_range(int'(depth_limit) + 1, 20'hFFFFF));
      end
      default: begin
        // Full-width noise; may land inside the range and still be kept.
        return 21'($urandom());
      end
    endcase
  endfunction

  // Zeroed coefficients after reset, default limit edges, bad depths.
  task automatic test_unloaded_coefficients();
    send_pixel(12'd0, 12'd0, 21'd1);
    send_pixel(12'd4095, 12'd4095, 21'(MAX_DEPTH_RESET));
    send_pixel(12'd100, 12'd200, 21'(MAX_DEPTH_RESET) + 21'd1);
    send_pixel(12'd5, 12'd5, 21'd0);
    send_pixel(12'd5, 12'd5, 21'h1FFFFF);
    send_pixel(12'd4095, 12'd0, 21'h100000);
  endtask

  // Extreme coefficients drive both camera and world points into saturation.
  task automatic test_extreme_frame();
    load_coef(COEF_FX, 32'h7FFF_FFFF);
    load_coef(COEF_FY, 32'h7FFF_FFFF);
    load_coef(COEF_CX, 32'h8000_0000);
    load_coef(COEF_CY, 32'h7FFF_FFFF);
    load_coef(COEF_R0, 32'h8000_0000);
    load_coef(COEF_R0 + 4'd4, 32'h7FFF_FFFF);
    load_coef(COEF_R0 + 4'd8, 32'h7FFF_FFFF);
    load_coef(COEF_T0, 32'h7FFF_FFFF);
    load_coef(COEF_T2, 32'h8000_0000);
    send_pixel(12'd4095, 12'd0, 21'(MAX_DEPTH_RESET));
    send_pixel(12'd0, 12'd4095, 21'd1);
  endtask

  // Limit of zero drops everything; largest limit keeps the largest depth.
  task automatic test_depth_limit();
    write_depth_limit(20'd0);
    send_pixel(12'd10, 12'd10, 21'd1);
    write_depth_limit(20'hFFFFF);
    send_pixel(12'd2048, 12'd1024, 21'h0FFFFF);
    write_depth_limit(20'd1);
    send_pixel(12'd1, 12'd2, 21'd1);
    send_pixel(12'd1, 12'd2, 21'd2);
  endtask

  // Frames of sixteen loads followed by pixels and stray loads, under several depth limits.
  task automatic test_random_frames();
    logic [19:0] limits [6];
    bit          wild;
    int          pick;
    limits = '{MAX_DEPTH_RESET, 20'hFFFFF, 20'd4096, 20'($urandom_range(1, 20'hFFFFF)),
               20'd1, 20'($urandom_range(1, 20'hFFFFF))};
    for (int ph = 0; ph < 6; ph++) begin
      write_depth_limit(limits[ph]);
      no_idle = (ph == 3);
      wild = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < 16; k++) begin
        load_coef(coef_idx_t'(k), pick_coef(coef_idx_t'(k), wild));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause mid-frame once until the pipeline is empty.
        if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          send_pixel(12'($urandom()), 12'($urandom()),
                     21'($urandom_range(1, int'(depth_limit))));
        end else if (pick < 95) begin
          send_pixel(12'($urandom()), 12'($urandom()), dropped_depth());
        end else begin
          pick = $urandom_range(0, 15);
          load_coef(coef_idx_t'(pick), pick_coef(coef_idx_t'(pick), $urandom_range(0, 1)));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int k = 0; k < 16; k++) frame_coef[k] = '0;
    depth_limit = MAX_DEPTH_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unloaded_coefficients();
    test_extreme_frame();
    test_depth_limit();
    test_random_frames();

    drain_results();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/dpw_pkg.sv
rtl/dpw_front.sv
rtl/dpw_queue.sv
rtl/dpw_back.sv
rtl/depth_pixels_to_world_points.sv
tb/tb_depth_pixels_to_world_points.sv
